>>> sv/hrsp_pkg.sv
// Package for the HTTP request stream parser: phase, target and result kind
// codes, character constants and the fixed text tables used to match tokens.
// No dependencies.
`default_nettype none

package hrsp_pkg;

    localparam int LEN_BITS_DEF = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_P     = 8'h50;

    localparam logic [3:0] MATCH_MAX   = 4'd15;
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] GET_LEN     = 4'd3;
    localparam logic [3:0] POST_LEN    = 4'd4;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URL,
        PH_VERSION,
        PH_NAME,
        PH_SKIP,
        PH_VALUE,
        PH_BODY,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_HOST,
        TGT_CTYPE,
        TGT_CLEN
    } t_target;

    typedef enum logic [2:0] {
        KIND_METHOD,
        KIND_URL,
        KIND_HOST,
        KIND_CTYPE,
        KIND_BODY,
        KIND_HDR_END,
        KIND_ERROR
    } t_kind;

    localparam logic [1:0] HDR_HOST  = 2'd0;
    localparam logic [1:0] HDR_CTYPE = 2'd1;
    localparam logic [1:0] HDR_CLEN  = 2'd2;

    typedef struct packed {
        t_phase     phase;
        logic [3:0] match_pos;
        logic [2:0] cand;
        t_target    target;
        logic       line_empty;
        logic       digit_seen;
        logic       method_bit;
    } t_ctl;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [7:0]  data;
        logic        meth;
        logic        done;
        logic [31:0] len;
    } t_result;

    function automatic logic [7:0] method_char(input logic meth, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (meth) begin
            case (pos)
                4'd1:    ch = "O";
                4'd2:    ch = "S";
                4'd3:    ch = "T";
                default: ch = 8'h00;
            endcase
        end else begin
            case (pos)
                4'd1:    ch = "E";
                4'd2:    ch = "T";
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            3'd5:    ch = "1";
            3'd6:    ch = ".";
            default: ch = "1";
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] hdr_len(input logic [1:0] idx);
        logic [3:0] len;
        unique case (idx)
            HDR_HOST:  len = 4'd4;
            HDR_CTYPE: len = 4'd12;
            HDR_CLEN:  len = 4'd14;
            default:   len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [111:0] txt;
        int           len;
        int           sh;
        unique case (idx)
            HDR_HOST:  txt = 112'("Host");
            HDR_CTYPE: txt = 112'("Content-Type");
            HDR_CLEN:  txt = 112'("Content-Length");
            default:   txt = '0;
        endcase
        len = int'(hdr_len(idx));
        if (int'(pos) < len) begin
            sh = 8 * (len - 1 - int'(pos));
            return txt[sh +: 8];
        end
        return 8'h00;
    endfunction

endpackage

`default_nettype wire

>>> sv/hrsp_step.sv
// Next-state and result logic of the parser for one byte.
// Depends on hrsp_pkg; purely combinational, registered by the top level.
`default_nettype none

module hrsp_step #(
    parameter int LEN_BITS = hrsp_pkg::LEN_BITS_DEF
) (
    input  wire  hrsp_pkg::t_ctl    i_ctl,
    input  wire  logic [LEN_BITS-1:0] i_len_accum,
    input  wire  logic [LEN_BITS-1:0] i_body_rem,
    input  wire  logic [7:0]        i_byte,
    output hrsp_pkg::t_ctl          o_ctl,
    output logic [LEN_BITS-1:0]     o_len_accum,
    output logic [LEN_BITS-1:0]     o_body_rem,
    output hrsp_pkg::t_result       o_res
);

    logic                is_cr;
    logic                is_lf;
    logic                is_sp;
    logic                is_colon;
    logic                is_digit;
    logic                mp_zero;
    logic                meth_over;
    logic                meth_char_ok;
    logic                ver_ok;
    logic                val_act;
    logic                w_fail;
    logic [2:0]          name_keep;
    hrsp_pkg::t_target   name_hit;
    logic [LEN_BITS+3:0] w_prod;
    logic [LEN_BITS-1:0] w_acc_next;
    logic [LEN_BITS-1:0] w_rem_dec;
    logic                w_rem_last;
    logic                w_acc_zero;
    logic [63:0]         w_len_wide;

    assign is_cr    = (i_byte == hrsp_pkg::CH_CR);
    assign is_lf    = (i_byte == hrsp_pkg::CH_LF);
    assign is_sp    = (i_byte == hrsp_pkg::CH_SP);
    assign is_colon = (i_byte == hrsp_pkg::CH_COLON);
    assign is_digit = (i_byte >= hrsp_pkg::CH_ZERO) && (i_byte <= hrsp_pkg::CH_NINE);

    assign mp_zero      = (i_ctl.match_pos == 4'd0);
    assign meth_over    = i_ctl.match_pos >= (i_ctl.method_bit ? hrsp_pkg::POST_LEN
                                                                : hrsp_pkg::GET_LEN);
    assign meth_char_ok = (i_byte == hrsp_pkg::method_char(i_ctl.method_bit,
                                                           i_ctl.match_pos));
    assign ver_ok       = (i_ctl.match_pos < hrsp_pkg::VERSION_LEN) &&
                          (i_byte == hrsp_pkg::version_char(i_ctl.match_pos[2:0]));
    assign val_act      = (i_ctl.phase == hrsp_pkg::PH_VALUE) ||
                          ((i_ctl.phase == hrsp_pkg::PH_SKIP) && !is_sp);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            name_keep[k] = i_ctl.cand[k] &&
                           (i_ctl.match_pos < hrsp_pkg::hdr_len(2'(k))) &&
                           (i_byte == hrsp_pkg::hdr_char(2'(k), i_ctl.match_pos));
        end
    end

    always_comb begin
        name_hit = hrsp_pkg::TGT_NONE;
        if (i_ctl.cand[0] && i_ctl.match_pos == hrsp_pkg::hdr_len(hrsp_pkg::HDR_HOST)) begin
            name_hit = hrsp_pkg::TGT_HOST;
        end
        if (i_ctl.cand[1] && i_ctl.match_pos == hrsp_pkg::hdr_len(hrsp_pkg::HDR_CTYPE)) begin
            name_hit = hrsp_pkg::TGT_CTYPE;
        end
        if (i_ctl.cand[2] && i_ctl.match_pos == hrsp_pkg::hdr_len(hrsp_pkg::HDR_CLEN)) begin
            name_hit = hrsp_pkg::TGT_CLEN;
        end
    end

    // Accumulate times ten plus the digit; any carry above the width saturates.
    assign w_prod = ((LEN_BITS+4)'(i_len_accum) << 3) + ((LEN_BITS+4)'(i_len_accum) << 1) +
                    (LEN_BITS+4)'(i_byte - hrsp_pkg::CH_ZERO);
    assign w_acc_next = (|w_prod[LEN_BITS+3:LEN_BITS]) ? {LEN_BITS{1'b1}}
                                                       : w_prod[LEN_BITS-1:0];
    assign w_rem_dec  = (i_body_rem != '0) ? i_body_rem - LEN_BITS'(1) : i_body_rem;
    assign w_rem_last = (w_rem_dec == '0);
    assign w_acc_zero = (i_len_accum == '0);
    assign w_len_wide = 64'(i_len_accum);

    always_comb begin
        w_fail = 1'b0;
        if (i_ctl.phase != hrsp_pkg::PH_ERROR && i_ctl.phase != hrsp_pkg::PH_BODY &&
            !is_cr) begin
            unique case (i_ctl.phase)
                hrsp_pkg::PH_METHOD: begin
                    if (mp_zero) begin
                        w_fail = !(i_byte == hrsp_pkg::CH_G || i_byte == hrsp_pkg::CH_P);
                    end else if (meth_over) begin
                        w_fail = !is_sp;
                    end else begin
                        w_fail = !meth_char_ok;
                    end
                end
                hrsp_pkg::PH_URL: begin
                    w_fail = is_lf;
                end
                hrsp_pkg::PH_VERSION: begin
                    w_fail = is_lf ? (i_ctl.match_pos != hrsp_pkg::VERSION_LEN) : !ver_ok;
                end
                hrsp_pkg::PH_NAME: begin
                    w_fail = is_lf && !i_ctl.line_empty;
                end
                hrsp_pkg::PH_SKIP, hrsp_pkg::PH_VALUE: begin
                    if (is_lf) begin
                        w_fail = (i_ctl.target == hrsp_pkg::TGT_CLEN) && !i_ctl.digit_seen;
                    end else begin
                        w_fail = val_act && (i_ctl.target == hrsp_pkg::TGT_CLEN) &&
                                 !i_ctl.digit_seen && !is_digit;
                    end
                end
                default: begin
                    w_fail = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_ctl       = i_ctl;
        o_len_accum = i_len_accum;
        o_body_rem  = i_body_rem;
        if (w_fail) begin
            o_ctl.phase = hrsp_pkg::PH_ERROR;
        end else if (i_ctl.phase == hrsp_pkg::PH_BODY) begin
            o_body_rem = w_rem_dec;
            if (w_rem_last) begin
                o_ctl.phase      = hrsp_pkg::PH_METHOD;
                o_ctl.match_pos  = '0;
                o_ctl.cand       = '1;
                o_ctl.target     = hrsp_pkg::TGT_NONE;
                o_ctl.line_empty = 1'b1;
                o_ctl.digit_seen = 1'b0;
                o_ctl.method_bit = 1'b0;
                o_len_accum      = '0;
                o_body_rem       = '0;
            end
        end else if (i_ctl.phase != hrsp_pkg::PH_ERROR && !is_cr) begin
            unique case (i_ctl.phase)
                hrsp_pkg::PH_METHOD: begin
                    if (mp_zero) begin
                        o_ctl.method_bit = (i_byte == hrsp_pkg::CH_P);
                        o_ctl.match_pos  = 4'd1;
                    end else if (meth_over) begin
                        o_ctl.phase     = hrsp_pkg::PH_URL;
                        o_ctl.match_pos = '0;
                    end else begin
                        o_ctl.match_pos = i_ctl.match_pos + 4'd1;
                    end
                end
                hrsp_pkg::PH_URL: begin
                    if (is_sp) begin
                        o_ctl.phase     = hrsp_pkg::PH_VERSION;
                        o_ctl.match_pos = '0;
                    end
                end
                hrsp_pkg::PH_VERSION: begin
                    if (is_lf) begin
                        o_ctl.phase      = hrsp_pkg::PH_NAME;
                        o_ctl.match_pos  = '0;
                        o_ctl.cand       = '1;
                        o_ctl.target     = hrsp_pkg::TGT_NONE;
                        o_ctl.line_empty = 1'b1;
                        o_ctl.digit_seen = 1'b0;
                    end else begin
                        o_ctl.match_pos = i_ctl.match_pos + 4'd1;
                    end
                end
                hrsp_pkg::PH_NAME: begin
                    if (is_lf) begin
                        if (w_acc_zero) begin
                            o_ctl.phase      = hrsp_pkg::PH_METHOD;
                            o_ctl.match_pos  = '0;
                            o_ctl.cand       = '1;
                            o_ctl.target     = hrsp_pkg::TGT_NONE;
                            o_ctl.line_empty = 1'b1;
                            o_ctl.digit_seen = 1'b0;
                            o_ctl.method_bit = 1'b0;
                            o_len_accum      = '0;
                            o_body_rem       = '0;
                        end else begin
                            o_ctl.phase = hrsp_pkg::PH_BODY;
                            o_body_rem  = i_len_accum;
                        end
                    end else begin
                        o_ctl.line_empty = 1'b0;
                        if (is_colon) begin
                            o_ctl.target = name_hit;
                            o_ctl.phase  = hrsp_pkg::PH_SKIP;
                            if (name_hit == hrsp_pkg::TGT_CLEN) begin
                                o_len_accum      = '0;
                                o_ctl.digit_seen = 1'b0;
                            end
                        end else begin
                            o_ctl.cand = name_keep;
                            if (i_ctl.match_pos < hrsp_pkg::MATCH_MAX) begin
                                o_ctl.match_pos = i_ctl.match_pos + 4'd1;
                            end
                        end
                    end
                end
                hrsp_pkg::PH_SKIP, hrsp_pkg::PH_VALUE: begin
                    if (is_lf) begin
                        o_ctl.phase      = hrsp_pkg::PH_NAME;
                        o_ctl.match_pos  = '0;
                        o_ctl.cand       = '1;
                        o_ctl.target     = hrsp_pkg::TGT_NONE;
                        o_ctl.line_empty = 1'b1;
                        o_ctl.digit_seen = 1'b0;
                    end else if (val_act) begin
                        o_ctl.phase = hrsp_pkg::PH_VALUE;
                        if (i_ctl.target == hrsp_pkg::TGT_CLEN) begin
                            if (is_digit) begin
                                o_len_accum      = w_acc_next;
                                o_ctl.digit_seen = 1'b1;
                            end else begin
                                o_ctl.target = hrsp_pkg::TGT_NONE;
                            end
                        end
                    end
                end
                default: begin
                    o_ctl.phase = hrsp_pkg::PH_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        o_res = '{valid: 1'b0, kind: hrsp_pkg::KIND_METHOD, data: 8'h00, meth: 1'b0,
                  done: 1'b0, len: 32'h0};
        if (w_fail) begin
            o_res.valid = 1'b1;
            o_res.kind  = hrsp_pkg::KIND_ERROR;
        end else if (i_ctl.phase == hrsp_pkg::PH_BODY) begin
            o_res.valid = 1'b1;
            o_res.kind  = hrsp_pkg::KIND_BODY;
            o_res.data  = i_byte;
            o_res.done  = w_rem_last;
            o_res.len   = w_len_wide[31:0];
        end else if (i_ctl.phase != hrsp_pkg::PH_ERROR && !is_cr) begin
            unique case (i_ctl.phase)
                hrsp_pkg::PH_METHOD: begin
                    if (!mp_zero && meth_over) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = hrsp_pkg::KIND_METHOD;
                        o_res.meth  = i_ctl.method_bit;
                    end
                end
                hrsp_pkg::PH_URL: begin
                    if (!is_sp) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = hrsp_pkg::KIND_URL;
                        o_res.data  = i_byte;
                    end
                end
                hrsp_pkg::PH_NAME: begin
                    if (is_lf && w_acc_zero) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = hrsp_pkg::KIND_HDR_END;
                        o_res.done  = 1'b1;
                    end
                end
                hrsp_pkg::PH_SKIP, hrsp_pkg::PH_VALUE: begin
                    if (!is_lf && val_act) begin
                        if (i_ctl.target == hrsp_pkg::TGT_HOST) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = hrsp_pkg::KIND_HOST;
                            o_res.data  = i_byte;
                        end else if (i_ctl.target == hrsp_pkg::TGT_CTYPE) begin
                            o_res.valid = 1'b1;
                            o_res.kind  = hrsp_pkg::KIND_CTYPE;
                            o_res.data  = i_byte;
                        end
                    end
                end
                default: begin
                    o_res.valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/http_request_stream_parser.sv
// HTTP/1.1 request stream parser, top level: state registers and result register.
// Depends on hrsp_pkg and hrsp_step.
//
// The block takes one raw request byte per item on the input channel and gives
// at most one result item per input item on the output channel. Results are
// the method, URL bytes, Host and Content-Type value bytes, body bytes with
// the parsed length, a marker for a request without body, and an error.
// An item accepted at one clock edge has its result presented from the next
// cycle on. The byte is decoded against the parser state combinationally, so
// one item can be accepted on every clock cycle while no result is stalled.
// A finished result sits in the output register; the next item is still taken
// in the cycle that result is taken. While the receiver stalls with a result
// pending, input ready is low and nothing is lost.
// Reset puts the parser at the start of a request line with the content
// length cleared and the output register empty. After an error the parser
// takes items but gives no results until the next reset.
`default_nettype none

module http_request_stream_parser #(
    parameter int LEN_BITS = hrsp_pkg::LEN_BITS_DEF
) (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_in_valid,
    output logic              o_in_ready,
    input  wire  logic [7:0]  i_data_byte,
    output logic              o_out_valid,
    input  wire  logic        i_out_ready,
    output logic [2:0]        o_out_kind,
    output logic [7:0]        o_out_byte,
    output logic              o_method_code,
    output logic              o_request_done,
    output logic [31:0]       o_body_length
);

    hrsp_pkg::t_ctl      r_ctl;
    hrsp_pkg::t_ctl      n_ctl;
    logic [LEN_BITS-1:0] r_len_accum;
    logic [LEN_BITS-1:0] n_len_accum;
    logic [LEN_BITS-1:0] r_body_rem;
    logic [LEN_BITS-1:0] n_body_rem;
    hrsp_pkg::t_result   n_res;
    logic                r_out_valid;
    hrsp_pkg::t_kind     r_out_kind;
    logic [7:0]          r_out_byte;
    logic                r_out_meth;
    logic                r_out_done;
    logic [31:0]         r_out_len;
    logic                w_accept;

    hrsp_step #(
        .LEN_BITS(LEN_BITS)
    ) u_step (
        .i_ctl       (r_ctl),
        .i_len_accum (r_len_accum),
        .i_body_rem  (r_body_rem),
        .i_byte      (i_data_byte),
        .o_ctl       (n_ctl),
        .o_len_accum (n_len_accum),
        .o_body_rem  (n_body_rem),
        .o_res       (n_res)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.phase      <= hrsp_pkg::PH_METHOD;
            r_ctl.match_pos  <= '0;
            r_ctl.cand       <= '1;
            r_ctl.target     <= hrsp_pkg::TGT_NONE;
            r_ctl.line_empty <= 1'b1;
            r_ctl.digit_seen <= 1'b0;
            r_ctl.method_bit <= 1'b0;
            r_len_accum      <= '0;
            r_body_rem       <= '0;
            r_out_valid      <= 1'b0;
        end else if (w_accept) begin
            r_ctl       <= n_ctl;
            r_len_accum <= n_len_accum;
            r_body_rem  <= n_body_rem;
            r_out_valid <= n_res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && n_res.valid) begin
            r_out_kind <= n_res.kind;
            r_out_byte <= n_res.data;
            r_out_meth <= n_res.meth;
            r_out_done <= n_res.done;
            r_out_len  <= n_res.len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_out_kind;
    assign o_out_byte     = r_out_byte;
    assign o_method_code  = r_out_meth;
    assign o_request_done = r_out_done;
    assign o_body_length  = r_out_len;

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == hrsp_pkg::PH_ERROR |=> r_ctl.phase == hrsp_pkg::PH_ERROR)
        else $error("parser left the error state without reset");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_ctl.phase == hrsp_pkg::PH_ERROR) |=> !r_out_valid)
        else $error("result produced after an error");

    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == hrsp_pkg::PH_BODY |-> r_body_rem != '0)
        else $error("body phase with no bytes remaining");

    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |->
            (r_out_kind == hrsp_pkg::KIND_BODY || r_out_kind == hrsp_pkg::KIND_HDR_END))
        else $error("request end marked on a result of the wrong kind");

endmodule

`default_nettype wire
